// ===== design/dllm_pkg.sv =====
// Shared types, field widths and codes for the doubly linked list manager.
package dllm_pkg;

    localparam int NODE_W         = 6;
    localparam int STATUS_W       = 2;
    localparam int NODE_COUNT_DEF = 64;
    localparam int POOL_MAX       = 1 << NODE_W;

    typedef enum logic {
        FUNC_ADD    = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE     = 2'd0,
        STAT_UNLISTED = 2'd1,
        STAT_LISTED   = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic start;   // request accepted this cycle
        logic commit;  // finish relink and load result
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy; // result register full and not being taken
    } dp_stat_t;

endpackage

// ===== design/dllm_ctrl.sv =====
// Sequencing state machine: accept, then relink and hand off the result.
module dllm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output dllm_pkg::ctrl_cmd_t  cmd,
    input  dllm_pkg::dp_stat_t   stat
);
    import dllm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LINK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd.start  = 1'b0;
        cmd.commit = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                // hold until the result register can take the new result
                if (!stat.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/dllm_dpath.sv =====
// Link memories, on-list marks, head/tail registers and the result register.
module dllm_dpath #(
    parameter int NODE_COUNT = dllm_pkg::NODE_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dllm_pkg::ctrl_cmd_t           cmd,
    output dllm_pkg::dp_stat_t            stat,
    input  logic                          in_func,
    input  logic [dllm_pkg::NODE_W-1:0]   in_node,
    input  logic                          in_at_head,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata
);
    import dllm_pkg::*;

    // only node indices the request field can name ever get storage
    localparam int POOL   = (NODE_COUNT < POOL_MAX) ? NODE_COUNT : POOL_MAX;
    localparam int POOL_W = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int LINK_W = $clog2(NODE_COUNT + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NODE_COUNT);

    logic [LINK_W-1:0] prev_mem [POOL];
    logic [LINK_W-1:0] next_mem [POOL];
    logic [LINK_W-1:0] prev_rd_reg;
    logic [LINK_W-1:0] next_rd_reg;

    logic [POOL-1:0]   on_list_reg;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;

    // latched request
    func_t             func_reg;
    logic [POOL_W-1:0] node_reg;
    logic              at_head_reg;
    logic              ok_reg;
    status_t           status_reg;

    logic              out_valid_reg;
    logic [15:0]       out_data_reg;

    // request checks
    logic              in_valid;
    logic              in_listed;
    logic              in_ok;
    status_t           in_status;
    logic [POOL_W-1:0] in_idx;
    logic [LINK_W-1:0] node_link;

    // memory write ports
    logic              prev_we, next_we;
    logic [POOL_W-1:0] prev_waddr, next_waddr;
    logic [LINK_W-1:0] prev_wdata, next_wdata;

    logic              empty_next;

    assign in_idx    = in_node[POOL_W-1:0];
    assign in_valid  = (32'(in_node) < NODE_COUNT);
    assign in_listed = in_valid && on_list_reg[in_idx];

    always_comb begin
        if (func_t'(in_func) == FUNC_ADD) begin
            in_ok     = in_valid && !in_listed;
            in_status = in_ok ? STAT_DONE : STAT_LISTED;
        end else begin
            in_ok     = in_valid && in_listed;
            in_status = in_ok ? STAT_DONE : STAT_UNLISTED;
        end
    end

    assign node_link = LINK_W'(node_reg);

    // adds write own links, then neighbors'; removes read links, then relink
    always_comb begin
        prev_we    = 1'b0;
        prev_waddr = in_idx;
        prev_wdata = NIL;
        next_we    = 1'b0;
        next_waddr = in_idx;
        next_wdata = NIL;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (cmd.start && in_ok && func_t'(in_func) == FUNC_ADD) begin
            prev_we    = 1'b1;
            next_we    = 1'b1;
            prev_wdata = in_at_head ? NIL : tail_reg;
            next_wdata = in_at_head ? head_reg : NIL;
        end
        if (cmd.commit && ok_reg) begin
            if (func_reg == FUNC_ADD) begin
                if (at_head_reg) begin
                    if (head_reg != NIL) begin
                        prev_we    = 1'b1;
                        prev_waddr = head_reg[POOL_W-1:0];
                        prev_wdata = node_link;
                    end else begin
                        tail_next = node_link;
                    end
                    head_next = node_link;
                end else begin
                    if (tail_reg != NIL) begin
                        next_we    = 1'b1;
                        next_waddr = tail_reg[POOL_W-1:0];
                        next_wdata = node_link;
                    end else begin
                        head_next = node_link;
                    end
                    tail_next = node_link;
                end
            end else begin
                if (prev_rd_reg != NIL) begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd_reg[POOL_W-1:0];
                    next_wdata = next_rd_reg;
                end
                if (next_rd_reg != NIL) begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd_reg[POOL_W-1:0];
                    prev_wdata = prev_rd_reg;
                end
                if (head_reg == node_link) begin
                    head_next = next_rd_reg;
                end
                if (tail_reg == node_link) begin
                    tail_next = prev_rd_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (cmd.start) begin
            prev_rd_reg <= prev_mem[in_idx];
            next_rd_reg <= next_mem[in_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            func_reg    <= func_t'(in_func);
            node_reg    <= in_idx;
            at_head_reg <= in_at_head;
            ok_reg      <= in_ok;
            status_reg  <= in_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_list_reg <= '0;
            head_reg    <= NIL;
            tail_reg    <= NIL;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (cmd.commit && ok_reg) begin
                on_list_reg[node_reg] <= (func_reg == FUNC_ADD);
            end
        end
    end

    // result register
    assign empty_next = (head_next == NIL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg[1:0]   <= status_reg;
            out_data_reg[7:2]   <= empty_next ? '0 : NODE_W'(head_next[POOL_W-1:0]);
            out_data_reg[13:8]  <= empty_next ? '0 : NODE_W'(tail_next[POOL_W-1:0]);
            out_data_reg[14]    <= empty_next;
            out_data_reg[15]    <= 1'b0;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign stat.out_busy = out_valid_reg && !m_tready;

endmodule

// ===== design/doubly_linked_list_manager_top.sv =====
// Top level of the doubly linked list manager: controller plus datapath.
//
// Usage:
//   Input channel (s_): one request per handshake. s_tuser carries the
//   operation (0 add, 1 remove); s_tdata carries the node index and, for
//   add, whether to link it at the head or the tail.
//   Output channel (m_): exactly one result per request, in request order:
//   status (0 done, 1 remove of an unlisted node, 2 add of a listed node),
//   head and tail indices after the operation (0 when empty) and an
//   empty flag.
//   Sequence: the request is taken in the idle state; the result register
//   is loaded when the link state commits, and m_tvalid is high after it.
//   No new request is taken until then, as each request needs two
//   passes over the single-write-port link memories (own links, then the
//   neighbor's link; or read links, then relink neighbors).
//   Stall: a result waiting in the output register does not block the next
//   request; its second step waits until the result register is free.
//   Reset (aresetn low, synchronous): list empty, all on-list marks clear,
//   no result pending. Link memories are not cleared; a node's links are
//   always written when it is added, before they are ever read.
module doubly_linked_list_manager_top #(
    parameter int NODE_COUNT = dllm_pkg::NODE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] node, [6] at_head, [7] zero fill
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [7:2] head_node,
                                   // [13:8] tail_node, [14] list_empty,
                                   // [15] zero fill
);
    import dllm_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    dllm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    dllm_dpath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_tuser[0]),
        .in_node    (s_tdata[NODE_W-1:0]),
        .in_at_head (s_tdata[NODE_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== tb/doubly_linked_list_manager_top_tb.sv =====
// Testbench for doubly_linked_list_manager_top: directed and random list requests vs a list model.
module doubly_linked_list_manager_top_tb;
    import dllm_pkg::*;

    localparam int               POOL       = NODE_COUNT_DEF;
    localparam logic [NODE_W:0]  NIL_IDX    = (NODE_W + 1)'(POOL);
    localparam int               RAND_ITEMS = 1150;
    localparam int               CYCLE_LIMIT = 200000;
    localparam int               DRAIN_CYCLES = 10;

    // One result word, unpacked into its fields.
    typedef struct packed {
        status_t           status;
        logic [NODE_W-1:0] head_node;
        logic [NODE_W-1:0] tail_node;
        logic              list_empty;
    } list_result_t;

    // Tracks the list as the block should hold it and checks each result.
    class list_state_checker;
        logic [NODE_W:0] prev_idx [POOL];
        logic [NODE_W:0] next_idx [POOL];
        bit              on_list_mark [POOL];
        logic [NODE_W:0] head_idx;
        logic [NODE_W:0] tail_idx;
        int unsigned     listed_total;
        list_result_t    expected_states[$];
        int unsigned     mismatch_count;

        function new();
            head_idx       = NIL_IDX;
            tail_idx       = NIL_IDX;
            listed_total   = 0;
            mismatch_count = 0;
            foreach (on_list_mark[i]) on_list_mark[i] = 0;
        endfunction

        // Applies one accepted request to the list and queues the result.
        function void note_request(func_t func, logic [NODE_W-1:0] node, logic at_head);
            list_result_t    res;
            logic [NODE_W:0] p;
            logic [NODE_W:0] x;
            logic [NODE_W:0] n;
            n = {1'b0, node};
            res.status = STAT_DONE;
            if (func == FUNC_ADD) begin
                if (on_list_mark[node]) begin
                    res.status = STAT_LISTED;
                end else if (at_head) begin
                    prev_idx[node] = NIL_IDX;
                    next_idx[node] = head_idx;
                    if (head_idx != NIL_IDX) prev_idx[head_idx] = n;
                    else tail_idx = n;
                    head_idx = n;
                end else begin
                    prev_idx[node] = tail_idx;
                    next_idx[node] = NIL_IDX;
                    if (tail_idx != NIL_IDX) next_idx[tail_idx] = n;
                    else head_idx = n;
                    tail_idx = n;
                end
                if (res.status == STAT_DONE) begin
                    on_list_mark[node] = 1;
                    listed_total++;
                end
            end else begin
                if (!on_list_mark[node]) begin
                    res.status = STAT_UNLISTED;
                end else begin
                    p = prev_idx[node];
                    x = next_idx[node];
                    if (p != NIL_IDX) next_idx[p] = x;
                    if (x != NIL_IDX) prev_idx[x] = p;
                    if (head_idx == n) head_idx = x;
                    if (tail_idx == n) tail_idx = p;
                    on_list_mark[node] = 0;
                    listed_total--;
                end
            end
            res.list_empty = (head_idx == NIL_IDX);
            res.head_node  = res.list_empty ? '0 : head_idx[NODE_W-1:0];
            res.tail_node  = res.list_empty ? '0 : tail_idx[NODE_W-1:0];
            expected_states.push_back(res);
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("mismatch: %s", what);
        endtask

        task check_result(logic [15:0] word);
            list_result_t want;
            list_result_t got;
            got.status     = status_t'(word[1:0]);
            got.head_node  = word[7:2];
            got.tail_node  = word[13:8];
            got.list_empty = word[14];
            if (expected_states.size() == 0) begin
                report_mismatch($sformatf("result 0x%04h with no request pending", word));
            end else begin
                want = expected_states.pop_front();
                if (got.status != want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              got.status, want.status));
                if (got.head_node != want.head_node)
                    report_mismatch($sformatf("head_node %0d, want %0d",
                                              got.head_node, want.head_node));
                if (got.tail_node != want.tail_node)
                    report_mismatch($sformatf("tail_node %0d, want %0d",
                                              got.tail_node, want.tail_node));
                if (got.list_empty != want.list_empty)
                    report_mismatch($sformatf("list_empty %0d, want %0d",
                                              got.list_empty, want.list_empty));
            end
        endtask

        function int unsigned pending();
            return expected_states.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [5:0] node, [6] at_head, [7] zero fill
    logic [0:0]  s_tuser  = '0;   // [0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [1:0] status, [7:2] head_node, [13:8] tail_node,
                                  // [14] list_empty, [15] zero fill

    list_state_checker list_check = new();
    bit          steady_flow = 0;  // set: neither side idles
    int unsigned cycle_count = 0;

    doubly_linked_list_manager_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[doubly_linked_list_manager_top] ERROR");
            $finish;
        end
    end

    // Result side: random back-pressure, changed at the falling edge.
    always @(negedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(0, 99) >= 30);
    end

    // Results are taken at the rising edge where valid and ready meet.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) list_check.check_result(m_tdata);
    end

    // Drives one request, with random gaps before it, and holds it until taken.
    task send_request(func_t func, logic [NODE_W-1:0] node, logic at_head);
        @(negedge aclk);
        while (!steady_flow && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= func;
        s_tdata    <= {1'b0, at_head, node};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        list_check.note_request(func, node, at_head);
    endtask

    // Holds the input quiet until every queued result has been taken.
    task wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (list_check.pending() != 0) @(posedge aclk);
    endtask

    // Random node that is (or is not) on the list right now; caller checks one exists.
    function automatic logic [NODE_W-1:0] pick_node(bit want_listed);
        int cand[$];
        for (int i = 0; i < POOL; i++)
            if (list_check.on_list_mark[i] == want_listed) cand.push_back(i);
        return NODE_W'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    initial begin
        int              fill_target;
        int unsigned     roll;
        func_t           func;
        logic [NODE_W-1:0] node;
        logic            at_head;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-list removes, first add by tail, duplicate adds,
        // removes of middle, head, tail and the last node, and a stale remove.
        send_request(FUNC_REMOVE, 6'd0,  1'b0);
        send_request(FUNC_REMOVE, 6'd63, 1'b1);
        send_request(FUNC_ADD,    6'd0,  1'b0);
        send_request(FUNC_ADD,    6'd0,  1'b1);
        send_request(FUNC_ADD,    6'd63, 1'b1);
        send_request(FUNC_ADD,    6'd21, 1'b0);
        send_request(FUNC_ADD,    6'd42, 1'b1);
        send_request(FUNC_ADD,    6'd63, 1'b0);
        send_request(FUNC_REMOVE, 6'd0,  1'b1);
        send_request(FUNC_REMOVE, 6'd42, 1'b0);
        send_request(FUNC_REMOVE, 6'd21, 1'b0);
        send_request(FUNC_REMOVE, 6'd21, 1'b1);
        send_request(FUNC_REMOVE, 6'd63, 1'b0);
        send_request(FUNC_ADD,    6'd42, 1'b1);
        send_request(FUNC_REMOVE, 6'd42, 1'b1);
        send_request(FUNC_ADD,    6'd63, 1'b0);
        send_request(FUNC_ADD,    6'd0,  1'b0);
        send_request(FUNC_REMOVE, 6'd0,  1'b0);
        send_request(FUNC_REMOVE, 6'd63, 1'b1);
        wait_for_results();

        // Random: the fill level is steered toward a target that moves
        // between empty, full and in between; a few requests are noise.
        fill_target = 0;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 150 == 0) begin
                case ((i / 150) % 3)
                    0:       fill_target = POOL;
                    1:       fill_target = 0;
                    default: fill_target = $urandom_range(1, POOL - 1);
                endcase
            end
            steady_flow = (i >= 500 && i < 700);
            if (i == 300) wait_for_results();

            roll    = $urandom_range(0, 99);
            at_head = 1'($urandom_range(0, 1));
            if (roll < 12) begin
                func = func_t'($urandom_range(0, 1));
                node = NODE_W'($urandom_range(0, POOL - 1));
            end else if (list_check.listed_total == 0 ||
                         (list_check.listed_total < POOL &&
                          (list_check.listed_total < fill_target ||
                           (list_check.listed_total == fill_target && roll < 56)))) begin
                func = FUNC_ADD;
                node = pick_node(1'b0);
            end else begin
                func = FUNC_REMOVE;
                node = pick_node(1'b1);
            end
            send_request(func, node, at_head);
        end
        steady_flow = 0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (list_check.pending() != 0) list_check.report_mismatch("results still expected");

        if (list_check.mismatch_count == 0) begin
            $display("[doubly_linked_list_manager_top] OK");
        end else begin
            $display("[doubly_linked_list_manager_top] ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/dllm_pkg.sv
design/dllm_ctrl.sv
design/dllm_dpath.sv
design/doubly_linked_list_manager_top.sv
tb/doubly_linked_list_manager_top_tb.sv
